// ----- hdl/scbl_pkg.sv -----
// ---------------------------------------------------------------------------
// scbl_pkg
// Shared types, codes and the control program of the serial command
// LED blinker sequencer.
// ---------------------------------------------------------------------------
package scbl_pkg;

    // result status codes
    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_DONE       = 3'd1;
    localparam logic [2:0] ST_BAD_STATE  = 3'd2;
    localparam logic [2:0] ST_BAD_COLOUR = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;
    localparam logic [2:0] ST_ZERO       = 3'd5;

    // characters of the command line
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_RED     = 8'h72;
    localparam logic [7:0] CH_GREEN   = 8'h67;
    localparam logic [7:0] CH_BLUE    = 8'h62;

    localparam logic [15:0] TICK_RATE_RESET = 16'd1000;
    localparam logic [16:0] NUM_CLAMP       = 17'd65536;
    localparam int          NUM_CHAN        = 3;

    typedef logic [4:0] t_pc;

    // program steps
    localparam t_pc S_IDLE    = 5'd0;
    localparam t_pc S_ISTICK  = 5'd1;
    localparam t_pc S_ISFULL  = 5'd2;
    localparam t_pc S_ISNL    = 5'd3;
    localparam t_pc S_STORE   = 5'd4;
    localparam t_pc S_TICK    = 5'd5;
    localparam t_pc S_OVF     = 5'd6;
    localparam t_pc S_LATCH   = 5'd7;
    localparam t_pc S_GETST   = 5'd8;
    localparam t_pc S_GETCOL  = 5'd9;
    localparam t_pc S_CHKCOL  = 5'd10;
    localparam t_pc S_CHKOFF  = 5'd11;
    localparam t_pc S_CHKON   = 5'd12;
    localparam t_pc S_DIGIT   = 5'd13;
    localparam t_pc S_CHKZERO = 5'd14;
    localparam t_pc S_DIV     = 5'd15;
    localparam t_pc S_ON      = 5'd16;
    localparam t_pc S_OFF     = 5'd17;
    localparam t_pc S_ERRCOL  = 5'd18;
    localparam t_pc S_ERRST   = 5'd19;
    localparam t_pc S_ERRZERO = 5'd20;
    localparam t_pc S_EMIT    = 5'd21;
    localparam t_pc S_RET     = 5'd22;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_STORE,
        OP_TICK,
        OP_OVF,
        OP_LATCH,
        OP_GETST,
        OP_GETCOL,
        OP_DIGIT,
        OP_DIVINIT,
        OP_DIV,
        OP_ON,
        OP_OFF,
        OP_ERRCOL,
        OP_ERRST,
        OP_ERRZERO
    } t_op;

    // a separate output-load op would not fit 4 bits; emit is decoded by step
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOBEAT,
        C_TICK,
        C_FULL,
        C_NEWLINE,
        C_BADCOL,
        C_OFF,
        C_NOTON,
        C_DIGIT,
        C_ZERO,
        C_DIVMORE,
        C_OUTBUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctl;

    // control store: taken jumps go to target, otherwise to the next step
    function automatic t_ctl ctl_rom(input t_pc pc);
        t_ctl c;
        c = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        unique case (pc)
            S_IDLE:    c = '{op: OP_CAPTURE, cond: C_NOBEAT,  target: S_IDLE};
            S_ISTICK:  c = '{op: OP_NOP,     cond: C_TICK,    target: S_TICK};
            S_ISFULL:  c = '{op: OP_NOP,     cond: C_FULL,    target: S_OVF};
            S_ISNL:    c = '{op: OP_NOP,     cond: C_NEWLINE, target: S_LATCH};
            S_STORE:   c = '{op: OP_STORE,   cond: C_ALWAYS,  target: S_EMIT};
            S_TICK:    c = '{op: OP_TICK,    cond: C_ALWAYS,  target: S_EMIT};
            S_OVF:     c = '{op: OP_OVF,     cond: C_ALWAYS,  target: S_EMIT};
            S_LATCH:   c = '{op: OP_LATCH,   cond: C_NEVER,   target: S_IDLE};
            S_GETST:   c = '{op: OP_GETST,   cond: C_NEVER,   target: S_IDLE};
            S_GETCOL:  c = '{op: OP_GETCOL,  cond: C_NEVER,   target: S_IDLE};
            S_CHKCOL:  c = '{op: OP_NOP,     cond: C_BADCOL,  target: S_ERRCOL};
            S_CHKOFF:  c = '{op: OP_NOP,     cond: C_OFF,     target: S_OFF};
            S_CHKON:   c = '{op: OP_NOP,     cond: C_NOTON,   target: S_ERRST};
            S_DIGIT:   c = '{op: OP_DIGIT,   cond: C_DIGIT,   target: S_DIGIT};
            S_CHKZERO: c = '{op: OP_DIVINIT, cond: C_ZERO,    target: S_ERRZERO};
            S_DIV:     c = '{op: OP_DIV,     cond: C_DIVMORE, target: S_DIV};
            S_ON:      c = '{op: OP_ON,      cond: C_ALWAYS,  target: S_EMIT};
            S_OFF:     c = '{op: OP_OFF,     cond: C_ALWAYS,  target: S_EMIT};
            S_ERRCOL:  c = '{op: OP_ERRCOL,  cond: C_ALWAYS,  target: S_EMIT};
            S_ERRST:   c = '{op: OP_ERRST,   cond: C_ALWAYS,  target: S_EMIT};
            S_ERRZERO: c = '{op: OP_ERRZERO, cond: C_ALWAYS,  target: S_EMIT};
            S_EMIT:    c = '{op: OP_NOP,     cond: C_OUTBUSY, target: S_EMIT};
            S_RET:     c = '{op: OP_NOP,     cond: C_ALWAYS,  target: S_IDLE};
            default:   c = '{op: OP_NOP,     cond: C_ALWAYS,  target: S_IDLE};
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/scbl_ram.sv -----
// ---------------------------------------------------------------------------
// scbl_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module scbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/serial_command_led_blinker_core.sv -----
// ---------------------------------------------------------------------------
// serial_command_led_blinker_core
// Line-based command parser driving three blinking LED channels.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per event. tuser = 1 marks a timer tick, tuser = 0 a
//   received byte in tdata. Bytes build a line of up to LINE_LEN bytes; a
//   newline runs the line as a command ("1r5", "0g", ...).
//   m_axis: exactly one result beat per input beat, in order, carrying the
//   LED levels, a status code and the period just set.
//   cfg: tick_rate write channel, always ready; write only while idle.
// Sequencing: each event runs from its accepting idle step to the emit step;
//   a tick, a stored byte or an overflow goes there directly, a newline
//   runs the command checks, and "on" also runs the restoring divider. The
//   beat shows on m_axis the cycle after the emit step and the sequencer
//   returns to idle through its return step.
//   The next event is taken as soon as the sequencer is back at idle, even
//   while the previous result still sits in the output register; if the
//   receiver stalls, the sequencer waits at its emit step.
// Reset: LEDs high, channels disabled, line empty, tick_rate = 1000.
// ---------------------------------------------------------------------------
module serial_command_led_blinker_core #(
    parameter int LINE_LEN = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
    input  logic        s_axis_tuser,  // [0] action
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] led_red, [1] led_green, [2] led_blue, [5:3] status,
    // [21:6] period_now, [23:22] zero
    output logic [23:0] m_axis_tdata,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(LINE_LEN);
    localparam int IW = $clog2(LINE_LEN + 1);
    localparam logic [IW-1:0] FULL = IW'(LINE_LEN);

    scbl_pkg::t_pc  r_pc;
    scbl_pkg::t_pc  n_pc;
    scbl_pkg::t_ctl w_ctl;
    logic           w_taken;

    logic [15:0]    r_tick_rate;
    logic           r_action;
    logic [7:0]     r_byte;
    logic [IW-1:0]  r_fill;
    logic [IW-1:0]  r_len;
    logic [IW-1:0]  r_idx;
    logic [IW-1:0]  n_idx;
    logic [7:0]     r_state_ch;
    logic [7:0]     r_colour;
    logic [16:0]    r_num;
    logic [15:0]    r_rem;
    logic [15:0]    r_quo;
    logic [3:0]     r_div_cnt;
    logic [2:0]     r_status;
    logic [15:0]    r_period_now;

    logic [scbl_pkg::NUM_CHAN-1:0] r_enable;
    logic [scbl_pkg::NUM_CHAN-1:0] r_led;
    logic [15:0]    r_chan_period [scbl_pkg::NUM_CHAN];
    logic [15:0]    r_tick_cnt    [scbl_pkg::NUM_CHAN];

    logic           r_out_valid;
    logic [2:0]     r_out_led;
    logic [2:0]     r_out_status;
    logic [15:0]    r_out_period;

    logic           w_in_beat;
    logic           w_ram_we;
    logic [7:0]     w_rdata;
    logic [7:0]     w_char;
    logic           w_is_digit;
    logic [19:0]    w_num_next;
    logic [1:0]     w_ch;
    logic           w_col_ok;
    logic [16:0]    w_trial;
    logic           w_fits;

    // ---------------- sequencer ----------------
    assign w_ctl     = scbl_pkg::ctl_rom(r_pc);
    assign w_in_beat = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_pc == scbl_pkg::S_IDLE);
    assign o_cfg_ready   = 1'b1;

    assign w_char     = (r_idx < r_len) ? w_rdata : 8'h00;
    assign w_is_digit = (w_char >= scbl_pkg::CH_ZERO) && (w_char <= scbl_pkg::CH_NINE);
    assign w_num_next = {r_num, 3'b000} + {2'b00, r_num, 1'b0}
                      + {12'd0, w_char - scbl_pkg::CH_ZERO};

    always_comb begin
        w_col_ok = 1'b1;
        w_ch     = 2'd0;
        priority if (r_colour == scbl_pkg::CH_RED) begin
            w_ch = 2'd0;
        end else if (r_colour == scbl_pkg::CH_GREEN) begin
            w_ch = 2'd1;
        end else if (r_colour == scbl_pkg::CH_BLUE) begin
            w_ch = 2'd2;
        end else begin
            w_col_ok = 1'b0;
        end
    end

    always_comb begin
        unique case (w_ctl.cond)
            scbl_pkg::C_NEVER:   w_taken = 1'b0;
            scbl_pkg::C_ALWAYS:  w_taken = 1'b1;
            scbl_pkg::C_NOBEAT:  w_taken = !w_in_beat;
            scbl_pkg::C_TICK:    w_taken = r_action;
            scbl_pkg::C_FULL:    w_taken = (r_fill == FULL);
            scbl_pkg::C_NEWLINE: w_taken = (r_byte == scbl_pkg::CH_NEWLINE);
            scbl_pkg::C_BADCOL:  w_taken = !w_col_ok;
            scbl_pkg::C_OFF:     w_taken = (r_state_ch == scbl_pkg::CH_ZERO);
            scbl_pkg::C_NOTON:   w_taken = (r_state_ch != scbl_pkg::CH_ONE);
            scbl_pkg::C_DIGIT:   w_taken = w_is_digit;
            scbl_pkg::C_ZERO:    w_taken = (r_num == 17'd0);
            scbl_pkg::C_DIVMORE: w_taken = (r_div_cnt != 4'd15);
            scbl_pkg::C_OUTBUSY: w_taken = r_out_valid;
            default:             w_taken = 1'b0;
        endcase
        n_pc = w_taken ? w_ctl.target : scbl_pkg::t_pc'(r_pc + 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= scbl_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // read address runs one step ahead so the registered data matches r_idx
    always_comb begin
        n_idx = r_idx;
        unique case (w_ctl.op)
            scbl_pkg::OP_LATCH:  n_idx = '0;
            scbl_pkg::OP_GETST,
            scbl_pkg::OP_GETCOL: n_idx = IW'(r_idx + 1'b1);
            scbl_pkg::OP_DIGIT:  n_idx = w_is_digit ? IW'(r_idx + 1'b1) : r_idx;
            default:             n_idx = r_idx;
        endcase
    end

    assign w_ram_we = (w_ctl.op == scbl_pkg::OP_STORE);

    scbl_ram #(
        .WIDTH (8),
        .DEPTH (LINE_LEN)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (r_byte),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // restoring divider, one quotient bit per step
    assign w_trial = {r_rem, r_quo[15]};
    assign w_fits  = (w_trial >= r_num);

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        unique case (w_ctl.op)
            scbl_pkg::OP_CAPTURE: begin
                if (w_in_beat) begin
                    r_action     <= s_axis_tuser;
                    r_byte       <= s_axis_tdata;
                    r_status     <= scbl_pkg::ST_NONE;
                    r_period_now <= '0;
                end
            end
            scbl_pkg::OP_LATCH: begin
                r_len <= r_fill;
                r_num <= '0;
            end
            scbl_pkg::OP_GETST:  r_state_ch <= w_char;
            scbl_pkg::OP_GETCOL: r_colour   <= w_char;
            scbl_pkg::OP_DIGIT: begin
                if (w_is_digit) begin
                    r_num <= (w_num_next > {3'b000, scbl_pkg::NUM_CLAMP})
                           ? scbl_pkg::NUM_CLAMP : w_num_next[16:0];
                end
            end
            scbl_pkg::OP_DIVINIT: begin
                r_rem     <= '0;
                r_quo     <= r_tick_rate;
                r_div_cnt <= '0;
            end
            scbl_pkg::OP_DIV: begin
                r_rem     <= w_fits ? 16'(w_trial - r_num) : w_trial[15:0];
                r_quo     <= {r_quo[14:0], w_fits};
                r_div_cnt <= r_div_cnt + 4'd1;
            end
            scbl_pkg::OP_ON: begin
                r_status     <= scbl_pkg::ST_DONE;
                r_period_now <= r_quo;
            end
            scbl_pkg::OP_OFF:     r_status <= scbl_pkg::ST_DONE;
            scbl_pkg::OP_OVF:     r_status <= scbl_pkg::ST_OVERFLOW;
            scbl_pkg::OP_ERRCOL:  r_status <= scbl_pkg::ST_BAD_COLOUR;
            scbl_pkg::OP_ERRST:   r_status <= scbl_pkg::ST_BAD_STATE;
            scbl_pkg::OP_ERRZERO: r_status <= scbl_pkg::ST_ZERO;
            default: begin
            end
        endcase
    end

    // line fill level, tick rate and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_tick_rate <= scbl_pkg::TICK_RATE_RESET;
            r_enable    <= '0;
            r_led       <= '1;
            for (int c = 0; c < scbl_pkg::NUM_CHAN; c++) begin
                r_chan_period[c] <= '0;
                r_tick_cnt[c]    <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tick_rate <= i_cfg_data;
            end
            unique case (w_ctl.op)
                scbl_pkg::OP_STORE: r_fill <= IW'(r_fill + 1'b1);
                scbl_pkg::OP_OVF,
                scbl_pkg::OP_LATCH: r_fill <= '0;
                scbl_pkg::OP_TICK: begin
                    for (int c = 0; c < scbl_pkg::NUM_CHAN; c++) begin
                        if (r_enable[c]) begin
                            if ({1'b0, r_tick_cnt[c]} + 17'd1 >= {1'b0, r_chan_period[c]}) begin
                                r_led[c]      <= !r_led[c];
                                r_tick_cnt[c] <= '0;
                            end else begin
                                r_tick_cnt[c] <= r_tick_cnt[c] + 16'd1;
                            end
                        end
                    end
                end
                scbl_pkg::OP_ON: begin
                    r_enable[w_ch]      <= 1'b1;
                    r_chan_period[w_ch] <= r_quo;
                end
                scbl_pkg::OP_OFF: begin
                    r_enable[w_ch] <= 1'b0;
                    r_led[w_ch]    <= (w_ch != 2'd0);
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pc == scbl_pkg::S_EMIT && !r_out_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pc == scbl_pkg::S_EMIT && !r_out_valid) begin
            r_out_led    <= r_led;
            r_out_status <= r_status;
            r_out_period <= r_period_now;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_period, r_out_status, r_out_led};

    // ---------------- assertions ----------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("line fill beyond line length");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == scbl_pkg::S_EMIT && !r_out_valid) |=> r_out_valid)
        else $error("emit step did not load the output register");

    a_period_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_period != 16'd0) |-> (r_out_status == scbl_pkg::ST_DONE))
        else $error("period reported without a completed command");

    a_on_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == scbl_pkg::S_ON) |-> ($past(r_pc) == scbl_pkg::S_DIV && $past(r_div_cnt) == 4'd15))
        else $error("channel enabled before division finished");

    a_digit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == scbl_pkg::S_DIGIT) |-> (r_idx <= r_len))
        else $error("digit scan ran past the line");

endmodule
